>>> rtl/core/assert_macros.svh
// Assertion helpers for the RTL, used by epfl_core. They compile away in synthesis builds.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Clocked property that is ignored while the active-low reset is asserted.
`define ASSERT_CLK_RST(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");

// Clocked property that is checked during reset too.
`define ASSERT_CLK(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");

`else

`define ASSERT_CLK_RST(label, clk, rst_n, prop)
`define ASSERT_CLK(label, clk, prop)

`endif

`endif

>>> rtl/core/epfl_pkg.sv
`timescale 1ns / 1ps

package epfl_pkg;

    localparam int POOL_SLOTS = 32;
    localparam int TYPE_COUNT = 3;

    localparam int SLOT_W = $clog2(POOL_SLOTS);
    localparam int LINK_W = $clog2(POOL_SLOTS + 1);

    // Fixed widths of the stream fields.
    localparam int SLOT_FIELD_W = 5;
    localparam int TYPE_FIELD_W = 2;
    localparam int STAT_FIELD_W = 2;
    localparam int IN_TDATA_W   = 8;
    localparam int OUT_PAYLOAD_W = STAT_FIELD_W + SLOT_FIELD_W + TYPE_FIELD_W;
    localparam int OUT_TDATA_W  = 16;

    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } t_command;

    typedef enum logic [STAT_FIELD_W-1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_NOT_USED = 2'd2
    } t_status;

    typedef struct packed {
        logic [TYPE_FIELD_W-1:0] etype;
        logic [SLOT_FIELD_W-1:0] slot;
        t_command                command;
    } t_cmd;

    typedef struct packed {
        logic [TYPE_FIELD_W-1:0] stype;
        logic [SLOT_FIELD_W-1:0] slot;
        t_status                 status;
    } t_rsp;

endpackage

>>> rtl/core/epfl_core.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Slot table and free-list head. The response is combinational from the
// current state; the state updates at the edge where i_fire is high.
module epfl_core import epfl_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_fire,
    input  t_cmd i_cmd,
    output t_rsp o_rsp
);

    logic [LINK_W-1:0] r_link [POOL_SLOTS];
    logic [TYPE_FIELD_W-1:0] r_type [POOL_SLOTS];
    logic [POOL_SLOTS-1:0] r_used;
    logic [LINK_W-1:0] r_head;

    logic              head_null;
    logic [SLOT_W-1:0] head_idx;
    logic [LINK_W-1:0] head_next;
    logic              slot_in_range;
    logic [SLOT_W-1:0] free_idx;
    logic              free_ok;
    logic [TYPE_FIELD_W-1:0] alloc_type;
    logic              do_alloc;
    logic              do_free;

    always_comb begin
        head_null = (32'(r_head) >= 32'(POOL_SLOTS));
        head_idx  = r_head[SLOT_W-1:0];
        // A link past the null marker is taken as null.
        head_next = (32'(r_link[head_idx]) > 32'(POOL_SLOTS)) ?
                    LINK_W'(POOL_SLOTS) : r_link[head_idx];

        slot_in_range = (32'(i_cmd.slot) < 32'(POOL_SLOTS));
        free_idx      = SLOT_W'(i_cmd.slot);
        free_ok       = slot_in_range && r_used[free_idx];

        // Types outside the known set are recorded as none.
        alloc_type = (32'(i_cmd.etype) >= 32'(TYPE_COUNT)) ? '0 : i_cmd.etype;

        do_alloc = i_fire && (i_cmd.command == CMD_ALLOC) && !head_null;
        do_free  = i_fire && (i_cmd.command == CMD_FREE) && free_ok;
    end

    always_comb begin
        o_rsp = '{stype: '0, slot: '0, status: ST_OK};
        unique case (i_cmd.command)
            CMD_ALLOC: begin
                if (head_null) begin
                    o_rsp.status = ST_EMPTY;
                end else begin
                    o_rsp.slot  = SLOT_FIELD_W'(head_idx);
                    o_rsp.stype = alloc_type;
                end
            end
            CMD_FREE: begin
                if (!free_ok) begin
                    o_rsp.status = ST_NOT_USED;
                end else begin
                    o_rsp.slot  = i_cmd.slot;
                    o_rsp.stype = r_type[free_idx];
                end
            end
            default: begin
                o_rsp.status = ST_NOT_USED;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < POOL_SLOTS; i++) begin
                r_link[i] <= LINK_W'(i + 1);
                r_type[i] <= '0;
            end
            r_used <= '0;
            r_head <= '0;
        end else begin
            if (do_alloc) begin
                r_head           <= head_next;
                r_type[head_idx] <= alloc_type;
                r_used[head_idx] <= 1'b1;
            end else if (do_free) begin
                r_link[free_idx] <= r_head;
                r_head           <= LINK_W'(free_idx);
                r_type[free_idx] <= '0;
                r_used[free_idx] <= 1'b0;
            end
        end
    end

    // The head of the free list must never point at a slot in use.
    `ASSERT_CLK_RST(a_head_is_free, i_clk, i_rst_n, do_alloc |-> !r_used[head_idx])

    // A successful free puts that slot at the head on the next cycle.
    `ASSERT_CLK_RST(a_free_pushes, i_clk, i_rst_n, do_free |=> (r_head == LINK_W'($past(free_idx))))

    // A successful allocate leaves the granted slot marked in use.
    `ASSERT_CLK_RST(a_alloc_marks, i_clk, i_rst_n, do_alloc |=> r_used[$past(head_idx)])

endmodule

>>> rtl/core/entity_pool_free_list.sv
`timescale 1ns / 1ps
// A command transfer passes through the input register and then the result register before its result is offered.
// One command per cycle while the result stream drains; the free-list head and slot tables update at the fire edge.
// Reset: synchronous, active low on i_rst_n; slots chained 0..N-1, head is slot 0, all slots unused.
// The handshake registers clear on reset; the payload registers are not reset.
module entity_pool_free_list import epfl_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Command stream.
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // tdata, from bit 0: command[0], slot[5:1], entity_type[7:6].
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    // Result stream.
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // tdata, from bit 0: status[1:0], granted_slot[6:2], slot_type[8:7], zeros above.
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata
);

    // The input register holds one command. It is executed against the slot
    // table when the result register is empty or is being drained in the
    // same cycle, so a full pipeline still moves one transfer per cycle.
    logic r_in_valid;
    t_cmd r_in;
    logic r_out_valid;
    t_rsp r_out;

    logic fire;
    t_rsp rsp;

    assign fire            = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_s_axis_tready) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in <= t_cmd'(i_s_axis_tdata);
        end
        if (fire) begin
            r_out <= rsp;
        end
    end

    // Slot table, free-list head and the per-command decision.
    epfl_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_cmd   (r_in),
        .o_rsp   (rsp)
    );

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(OUT_TDATA_W - OUT_PAYLOAD_W){1'b0}}, r_out};

endmodule

>>> test/entity_pool_free_list_tb.sv
`timescale 1ns / 1ps

module entity_pool_free_list_tb;
    import epfl_pkg::*;

    localparam int RST_CYCLES   = 6;
    localparam int STALL_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 80;
    localparam int DRAIN_CYCLES = 8;

    logic                   i_clk           = 1'b0;
    logic                   i_rst_n         = 1'b0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    // tdata, from bit 0: command[0], slot[5:1], entity_type[7:6].
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata  = '0;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    // tdata, from bit 0: status[1:0], granted_slot[6:2], slot_type[8:7], zeros above.
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;

    entity_pool_free_list u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Shadow copy of the slot pool, updated at each accepted command transfer.
    logic [LINK_W-1:0]       pool_link  [POOL_SLOTS];
    logic [LINK_W-1:0]       pool_head;
    logic [TYPE_FIELD_W-1:0] pool_kind  [POOL_SLOTS];
    logic                    pool_used  [POOL_SLOTS];
    logic                    pool_shown [POOL_SLOTS];

    t_rsp rsp_expected_q[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int rx_hold_req   = 0;
    int err_cnt       = 0;
    int sent_cnt      = 0;
    int ok_cnt        = 0;
    int empty_cnt     = 0;
    int unused_cnt    = 0;

    function automatic void pool_clear();
        for (int i = 0; i < POOL_SLOTS; i++) begin
            pool_link[i]  = LINK_W'(i + 1);
            pool_kind[i]  = '0;
            pool_used[i]  = 1'b0;
            pool_shown[i] = 1'b0;
        end
        pool_head = '0;
    endfunction

    // Applies one command to the shadow pool and returns the result it must produce.
    function automatic t_rsp pool_apply(input t_cmd c);
        t_rsp                    r;
        logic [LINK_W-1:0]       nxt;
        logic [TYPE_FIELD_W-1:0] kind;
        logic [SLOT_W-1:0]       hidx;
        r = '{stype: '0, slot: '0, status: ST_OK};
        if (c.command == CMD_ALLOC) begin
            if (pool_head >= POOL_SLOTS) begin
                r.status = ST_EMPTY;
            end else begin
                hidx = pool_head[SLOT_W-1:0];
                nxt  = pool_link[hidx];
                if (nxt > POOL_SLOTS) begin
                    nxt = LINK_W'(POOL_SLOTS);
                end
                // A type code past the table is stored as none.
                kind = (c.etype >= TYPE_COUNT) ? '0 : c.etype;
                pool_kind[hidx]  = kind;
                pool_used[hidx]  = 1'b1;
                pool_shown[hidx] = 1'b1;
                r.slot  = SLOT_FIELD_W'(hidx);
                r.stype = kind;
                pool_head = nxt;
            end
        end else if (c.slot >= POOL_SLOTS || !pool_used[c.slot]) begin
            r.status = ST_NOT_USED;
        end else begin
            r.slot  = c.slot;
            r.stype = pool_kind[c.slot];
            pool_kind[c.slot]  = '0;
            pool_used[c.slot]  = 1'b0;
            pool_shown[c.slot] = 1'b0;
            pool_link[c.slot]  = pool_head;
            pool_head          = LINK_W'(c.slot);
        end
        return r;
    endfunction

    // Offers one command, with random idle cycles first, and waits for its transfer.
    // Valid stays high after the transfer so back-to-back commands need no gap.
    task automatic send_cmd(input t_command cmd, input logic [SLOT_FIELD_W-1:0] slot,
                            input logic [TYPE_FIELD_W-1:0] etype);
        t_cmd item;
        item = '{etype: etype, slot: slot, command: cmd};
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= item;
        @(posedge i_clk);
        while (!o_s_axis_tready) begin
            @(posedge i_clk);
        end
        rsp_expected_q.push_back(pool_apply(item));
        sent_cnt++;
    endtask

    // Drops valid and waits until every predicted result has come back.
    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (rsp_expected_q.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic check_result(input logic [OUT_TDATA_W-1:0] data);
        t_rsp got;
        t_rsp want;
        got = t_rsp'(data[OUT_PAYLOAD_W-1:0]);
        if (rsp_expected_q.size() == 0) begin
            $error("result transfer with nothing expected: tdata %h", data);
            err_cnt++;
        end else begin
            want = rsp_expected_q.pop_front();
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                err_cnt++;
            end
            if (got.slot !== want.slot) begin
                $error("granted_slot: expected %0d, got %0d", want.slot, got.slot);
                err_cnt++;
            end
            if (got.stype !== want.stype) begin
                $error("slot_type: expected %0d, got %0d", want.stype, got.stype);
                err_cnt++;
            end
            case (want.status)
                ST_OK:    ok_cnt++;
                ST_EMPTY: empty_cnt++;
                default:  unused_cnt++;
            endcase
        end
    endtask

    // Result side: checks each transfer and drives tready, honoring a requested hold-off.
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
                check_result(o_m_axis_tdata);
            end
            if (hold_left == 0 && rx_hold_req > 0) begin
                hold_left   = rx_hold_req;
                rx_hold_req = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Ends the run if no transfer happens on either side for too long.
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready) ||
                (o_m_axis_tvalid && i_m_axis_tready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("no transfer for %0d cycles", STALL_LIMIT);
        $display("entity_pool_free_list_tb: done, errors");
        $finish;
    end

    // Field extremes, every type code, ignored fields, LIFO reuse and a double free.
    task automatic test_directed();
        send_cmd(CMD_ALLOC, 5'd0,  2'd0);
        send_cmd(CMD_ALLOC, 5'd31, 2'd1);
        send_cmd(CMD_ALLOC, 5'd0,  2'd2);
        send_cmd(CMD_ALLOC, 5'd17, 2'd3);
        send_cmd(CMD_FREE,  5'd31, 2'd0);
        send_cmd(CMD_FREE,  5'd2,  2'd3);
        send_cmd(CMD_FREE,  5'd2,  2'd0);
        send_cmd(CMD_ALLOC, 5'd31, 2'd2);
        send_cmd(CMD_FREE,  5'd0,  2'd1);
        send_cmd(CMD_FREE,  5'd1,  2'd2);
        send_cmd(CMD_ALLOC, 5'd10, 2'd1);
        send_cmd(CMD_ALLOC, 5'd21, 2'd3);
        send_cmd(CMD_ALLOC, 5'd0,  2'd2);
        send_cmd(CMD_FREE,  5'd3,  2'd0);
        send_cmd(CMD_FREE,  5'd2,  2'd0);
        send_cmd(CMD_FREE,  5'd1,  2'd0);
        send_cmd(CMD_FREE,  5'd0,  2'd3);
        send_cmd(CMD_FREE,  5'd4,  2'd0);
        send_cmd(CMD_FREE,  5'd4,  2'd0);
        drain();
    endtask

    // Exhausts the pool, allocates on empty, then frees every slot.
    task automatic test_pool_empty();
        while (pool_head < POOL_SLOTS) begin
            send_cmd(CMD_ALLOC, SLOT_FIELD_W'($urandom), TYPE_FIELD_W'($urandom));
        end
        send_cmd(CMD_ALLOC, 5'd31, 2'd1);
        send_cmd(CMD_ALLOC, 5'd0,  2'd2);
        send_cmd(CMD_FREE,  5'd31, 2'd0);
        send_cmd(CMD_ALLOC, 5'd5,  2'd2);
        send_cmd(CMD_ALLOC, 5'd6,  2'd1);
        for (int s = POOL_SLOTS - 1; s >= 0; s--) begin
            send_cmd(CMD_FREE, SLOT_FIELD_W'(s), TYPE_FIELD_W'($urandom));
        end
        drain();
    endtask

    // Mostly well-formed traffic: allocations and frees of slots in use, with the
    // allocation bias shifting so the pool both drains and fills. Some noise mixed in.
    task automatic test_random(input int n_items);
        int busy_q[$];
        int bias;
        int pick;
        bias = 50;
        for (int i = 0; i < n_items; i++) begin
            if (i % 40 == 0) begin
                case ($urandom_range(2))
                    0:       bias = 25;
                    1:       bias = 50;
                    default: bias = 85;
                endcase
            end
            busy_q.delete();
            for (int s = 0; s < POOL_SLOTS; s++) begin
                if (pool_used[s]) begin
                    busy_q.push_back(s);
                end
            end
            pick = $urandom_range(99);
            if (pick < 12) begin
                send_cmd(t_command'($urandom_range(1)), SLOT_FIELD_W'($urandom),
                         TYPE_FIELD_W'($urandom));
            end else if ($urandom_range(99) < bias || busy_q.size() == 0) begin
                send_cmd(CMD_ALLOC, SLOT_FIELD_W'($urandom), TYPE_FIELD_W'($urandom));
            end else begin
                send_cmd(CMD_FREE,
                         SLOT_FIELD_W'(busy_q[$urandom_range(busy_q.size() - 1)]),
                         TYPE_FIELD_W'($urandom));
            end
        end
        drain();
    endtask

    // The receiver holds off while the sender keeps offering, so the block fills
    // up and has to stall its command input.
    task automatic test_backpressure();
        rx_hold_req = HOLD_CYCLES;
        for (int i = 0; i < 40; i++) begin
            send_cmd(t_command'($urandom_range(1)), SLOT_FIELD_W'($urandom_range(7)),
                     TYPE_FIELD_W'($urandom));
        end
        drain();
    endtask

    initial begin
        pool_clear();
        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 21;
        recv_idle_pct = 85;
        test_directed();
        test_pool_empty();
        test_random(140);

        send_idle_pct = 85;
        recv_idle_pct = 21;
        test_random(140);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_backpressure();
        test_random(140);

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("%0d command transfers checked: %0d granted or released, %0d on an empty pool,",
                 sent_cnt, ok_cnt, empty_cnt);
        $display("%0d frees of idle slots; both sides throttled and one long result stall",
                 unused_cnt);
        if (err_cnt == 0) begin
            $display("entity_pool_free_list_tb: done, clean");
        end else begin
            $display("entity_pool_free_list_tb: done, errors");
        end
        $finish;
    end

endmodule
